>>> rtl/fhmc_pkg.sv
// Shared types and constants for the font handle MRU cache.
package fhmc_pkg;

  localparam int unsigned KEY_W    = 32;
  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned MASK_W   = 32;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_RES
  } state_e;

  typedef struct packed {
    logic flush;
    logic shift;
  } cell_ctrl_t;

endpackage

>>> rtl/fhmc_ram.sv
// Generic single write port RAM with registered read.
module fhmc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/fhmc_cell.sv
// One entry of the most-recent-first list: key, handle and key compare.
module fhmc_cell import fhmc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cell_ctrl_t          ctrl_i,
  input  logic [KEY_W-1:0]    key_prev_i,
  input  logic [HANDLE_W-1:0] handle_prev_i,
  input  logic [KEY_W-1:0]    search_key_i,
  output logic [KEY_W-1:0]    key_o,
  output logic [HANDLE_W-1:0] handle_o,
  output logic                match_o
);

  logic [KEY_W-1:0]    key_q;
  logic [HANDLE_W-1:0] handle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q    <= '0;
      handle_q <= '0;
    end else if (ctrl_i.flush) begin
      key_q    <= '0;
      handle_q <= '0;
    end else if (ctrl_i.shift) begin
      key_q    <= key_prev_i;
      handle_q <= handle_prev_i;
    end
  end

  assign match_o  = (key_q == search_key_i);
  assign key_o    = key_q;
  assign handle_o = handle_q;

endmodule

>>> rtl/font_handle_mru_cache.sv
// Top level of the font handle MRU cache: sequencer, direct table and list chain.
//
// Input channel (in_valid_i / in_stall_o) carries op_i, key_i and new_handle_i;
// an item is taken on a clock edge with in_valid_i high and in_stall_o low.
// Output channel (out_valid_o / out_stall_i) returns one result item per input
// item: handle_o, hit_o, evict_valid_o, evicted_handle_o.
// Key bits set in the layout strip mask (cfg_we_i / cfg_wdata_i) are cleared
// before lookup. Short keys index a table of 2**BASIC_BITS handles held in a
// RAM; other keys search a row of LIST_DEPTH cells kept most recent first.
// An accepted item passes through ST_LOOK (RAM read and cell compare) and then
// ST_RES (update), where the result is registered. The next item is taken only
// after that update has been committed, as the sequencer holds in_stall_o high.
// A flush additionally sweeps all 2**BASIC_BITS entries of the direct table,
// one entry a cycle, before the next item is taken.
// After reset the same sweep runs with in_stall_o high; the mask and the list
// cells clear at once.
// If the receiver stalls, the result waits in the output register; one more
// item may be taken, and its update waits until the output register frees.
module font_handle_mru_cache import fhmc_pkg::*; #(
  parameter int unsigned BASIC_BITS = 8,
  parameter int unsigned LIST_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [MASK_W-1:0]   cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                op_i,
  input  logic [KEY_W-1:0]    key_i,
  input  logic [HANDLE_W-1:0] new_handle_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [HANDLE_W-1:0] handle_o,
  output logic                hit_o,
  output logic                evict_valid_o,
  output logic [HANDLE_W-1:0] evicted_handle_o
);

  localparam int unsigned DIRECT_DEPTH = 1 << BASIC_BITS;

  state_e state_q, state_d;

  logic [MASK_W-1:0]     mask_q;
  logic [BASIC_BITS-1:0] clr_cnt_q, clr_cnt_d;

  logic                  op_q;
  logic [KEY_W-1:0]      key_q;
  logic [HANDLE_W-1:0]   nh_q;
  logic                  direct_q;
  logic [LIST_DEPTH-1:0] match_q;
  logic [HANDLE_W-1:0]   found_handle_q;

  logic [KEY_W-1:0]    key_strip;
  logic                accept;
  logic                slot_free;
  logic                commit;
  logic                list_upd;
  logic                found;
  logic [HANDLE_W-1:0] front_handle;
  logic [HANDLE_W-1:0] tail_handle;
  logic [HANDLE_W-1:0] found_handle;

  logic                  ram_we;
  logic [BASIC_BITS-1:0] ram_waddr;
  logic [HANDLE_W-1:0]   ram_wdata;
  logic [HANDLE_W-1:0]   ram_rdata;

  cell_ctrl_t            cell_ctrl [LIST_DEPTH];
  logic [KEY_W-1:0]      cell_key [LIST_DEPTH];
  logic [HANDLE_W-1:0]   cell_handle [LIST_DEPTH];
  logic [LIST_DEPTH-1:0] match_vec;

  logic                out_valid_q;
  logic [HANDLE_W-1:0] res_handle;
  logic                res_hit;
  logic                res_ev_valid;
  logic [HANDLE_W-1:0] res_ev_handle;
  logic [HANDLE_W-1:0] handle_q;
  logic                hit_q;
  logic                ev_valid_q;
  logic [HANDLE_W-1:0] ev_handle_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else if (cfg_we_i) begin
      mask_q <= cfg_wdata_i;
    end
  end

  assign key_strip = key_i & ~mask_q;
  assign accept    = in_valid_i && !in_stall_o;
  assign slot_free = !out_valid_q || !out_stall_i;
  assign commit    = (state_q == ST_RES) && slot_free;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_cnt_q == '1) state_d = ST_IDLE;
      ST_IDLE:  if (accept) state_d = ST_LOOK;
      ST_LOOK:  state_d = ST_RES;
      ST_RES: begin
        if (slot_free) begin
          state_d = (op_q == OP_FLUSH) ? ST_CLEAR : ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    clr_cnt_d  = clr_cnt_q;
    unique case (state_q)
      ST_CLEAR: clr_cnt_d = clr_cnt_q + 1'b1;
      ST_IDLE:  in_stall_o = 1'b0;
      ST_LOOK:  clr_cnt_d = '0;
      ST_RES:   clr_cnt_d = '0;
      default:  in_stall_o = 1'b1;
    endcase
  end

  // item registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= op_i;
      key_q    <= key_strip;
      nh_q     <= new_handle_i;
      direct_q <= (key_strip[KEY_W-1:BASIC_BITS] == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q        <= '0;
      found_handle_q <= '0;
    end else if (state_q == ST_LOOK) begin
      match_q        <= (op_q == OP_LOOKUP && !direct_q) ? match_vec : '0;
      found_handle_q <= found_handle;
    end
  end

  always_comb begin
    found_handle = '0;
    for (int unsigned i = 0; i < LIST_DEPTH; i++) begin
      found_handle = found_handle | (match_vec[i] ? cell_handle[i] : '0);
    end
  end

  // direct table
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = key_q[BASIC_BITS-1:0];
    ram_wdata = nh_q;
    if (state_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q;
      ram_wdata = '0;
    end else if (commit && op_q == OP_LOOKUP && direct_q && ram_rdata == '0) begin
      ram_we = 1'b1;
    end
  end

  fhmc_ram #(
    .WIDTH (HANDLE_W),
    .DEPTH (DIRECT_DEPTH)
  ) u_direct (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (key_strip[BASIC_BITS-1:0]),
    .rdata_o (ram_rdata)
  );

  // list chain
  assign list_upd     = commit && op_q == OP_LOOKUP && !direct_q;
  assign found        = |match_q;
  assign front_handle = found ? found_handle_q : nh_q;
  assign tail_handle  = cell_handle[LIST_DEPTH-1];

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    assign cell_ctrl[i].flush = commit && op_q == OP_FLUSH;
    assign cell_ctrl[i].shift = list_upd && (!found || (|(match_q >> i)));

    if (i == 0) begin : g_front
      fhmc_cell u_cell (
        .clk_i         (clk_i),
        .rst_ni        (rst_ni),
        .ctrl_i        (cell_ctrl[i]),
        .key_prev_i    (key_q),
        .handle_prev_i (front_handle),
        .search_key_i  (key_q),
        .key_o         (cell_key[i]),
        .handle_o      (cell_handle[i]),
        .match_o       (match_vec[i])
      );
    end else begin : g_rest
      fhmc_cell u_cell (
        .clk_i         (clk_i),
        .rst_ni        (rst_ni),
        .ctrl_i        (cell_ctrl[i]),
        .key_prev_i    (cell_key[i-1]),
        .handle_prev_i (cell_handle[i-1]),
        .search_key_i  (key_q),
        .key_o         (cell_key[i]),
        .handle_o      (cell_handle[i]),
        .match_o       (match_vec[i])
      );
    end
  end

  // result
  always_comb begin
    res_handle    = '0;
    res_hit       = 1'b0;
    res_ev_valid  = 1'b0;
    res_ev_handle = '0;
    if (op_q == OP_LOOKUP) begin
      if (direct_q) begin
        res_hit    = (ram_rdata != '0);
        res_handle = res_hit ? ram_rdata : nh_q;
      end else begin
        res_handle = front_handle;
        res_hit    = found && (found_handle_q != '0);
        if (!found) begin
          res_ev_handle = tail_handle;
          res_ev_valid  = (tail_handle != '0);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= commit || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      handle_q    <= res_handle;
      hit_q       <= res_hit;
      ev_valid_q  <= res_ev_valid;
      ev_handle_q <= res_ev_handle;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign handle_o         = handle_q;
  assign hit_o            = hit_q;
  assign evict_valid_o    = ev_valid_q;
  assign evicted_handle_o = ev_handle_q;

  a_match_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RES |-> $onehot0(match_q))
    else $error("several list entries match one key");

  a_flush_sweeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && op_q == OP_FLUSH) |=> state_q == ST_CLEAR)
    else $error("flush did not start table sweep");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_RES)
    else $error("result appeared outside update step");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(hit_q && ev_valid_q))
    else $error("hit and eviction on one item");

  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR || state_q == ST_RES) |-> !accept)
    else $error("item taken while busy");

endmodule

>>> tb/handle_cache_checker.sv
// Monitor, cache model and result comparison for the font handle MRU cache.
`timescale 1ns / 100ps
module handle_cache_checker import fhmc_pkg::*; #(
  parameter int unsigned BASIC_BITS = 8,
  parameter int unsigned LIST_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [MASK_W-1:0]   cfg_wdata_i,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic                op_i,
  input  logic [KEY_W-1:0]    key_i,
  input  logic [HANDLE_W-1:0] new_handle_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic [HANDLE_W-1:0] handle_i,
  input  logic                hit_i,
  input  logic                evict_valid_i,
  input  logic [HANDLE_W-1:0] evicted_handle_i,
  output int                  mismatches_o,
  output int                  pending_o
);

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic                hit;
    logic                evict_valid;
    logic [HANDLE_W-1:0] evicted_handle;
  } lookup_answer_t;

  logic [MASK_W-1:0]   strip_mask;
  logic [HANDLE_W-1:0] table_handles [1 << BASIC_BITS];
  logic [KEY_W-1:0]    mru_keys      [LIST_DEPTH];
  logic [HANDLE_W-1:0] mru_handles   [LIST_DEPTH];
  lookup_answer_t      answers_q [$];
  int                  mismatches = 0;

  assign mismatches_o = mismatches;

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic void wipe_stores();
    foreach (table_handles[i]) table_handles[i] = '0;
    foreach (mru_keys[i]) begin
      mru_keys[i]    = '0;
      mru_handles[i] = '0;
    end
  endfunction

  function automatic void push_front(int unsigned last, logic [KEY_W-1:0] k,
                                     logic [HANDLE_W-1:0] h);
    for (int unsigned j = last; j > 0; j--) begin
      mru_keys[j]    = mru_keys[j-1];
      mru_handles[j] = mru_handles[j-1];
    end
    mru_keys[0]    = k;
    mru_handles[0] = h;
  endfunction

  function automatic lookup_answer_t cache_lookup(logic op, logic [KEY_W-1:0] key,
                                                  logic [HANDLE_W-1:0] nh);
    lookup_answer_t        ans;
    logic [KEY_W-1:0]      k;
    int                    slot;
    logic [BASIC_BITS-1:0] idx;
    ans  = '0;
    slot = -1;
    if (op == OP_FLUSH) begin
      wipe_stores();
      return ans;
    end
    k = key & ~strip_mask;
    if ((k >> BASIC_BITS) == 0) begin
      idx = k[BASIC_BITS-1:0];
      if (table_handles[idx] != '0) ans.hit = 1'b1;
      else table_handles[idx] = nh;
      ans.handle = table_handles[idx];
    end else begin
      for (int i = LIST_DEPTH - 1; i >= 0; i--)
        if (mru_keys[i] == k) slot = i;
      if (slot >= 0) begin
        ans.handle = mru_handles[slot];
        ans.hit    = (ans.handle != '0);
        push_front(unsigned'(slot), k, ans.handle);
      end else begin
        ans.evicted_handle = mru_handles[LIST_DEPTH-1];
        ans.evict_valid    = (ans.evicted_handle != '0);
        ans.handle         = nh;
        push_front(LIST_DEPTH - 1, k, nh);
      end
    end
    return ans;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lookup_answer_t want;
    if (!rst_ni) begin
      strip_mask = '0;
      wipe_stores();
      answers_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) strip_mask = cfg_wdata_i;
      if (out_valid_i && !out_stall_i) begin
        if (answers_q.size() == 0) begin
          $display("%0t result item with nothing outstanding", $realtime);
          mismatches++;
        end else begin
          want = answers_q.pop_front();
          if (handle_i !== want.handle)
            report_mismatch("handle", handle_i, want.handle);
          if (hit_i !== want.hit)
            report_mismatch("hit", 32'(hit_i), 32'(want.hit));
          if (evict_valid_i !== want.evict_valid)
            report_mismatch("evict_valid", 32'(evict_valid_i), 32'(want.evict_valid));
          if (evicted_handle_i !== want.evicted_handle)
            report_mismatch("evicted_handle", evicted_handle_i, want.evicted_handle);
        end
      end
      if (in_valid_i && !in_stall_i)
        answers_q.insert(answers_q.size(), cache_lookup(op_i, key_i, new_handle_i));
      pending_o <= answers_q.size();
    end
  end

endmodule

>>> tb/testbench.sv
// Stimulus, clock, reset and verdict for the font handle MRU cache.
`timescale 1ns / 100ps
module testbench import fhmc_pkg::*; ();

  localparam int unsigned BASIC_BITS = 8;
  localparam int unsigned LIST_DEPTH = 16;
  localparam int unsigned PHASE_ITEMS = 180;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [MASK_W-1:0]   cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                op = OP_LOOKUP;
  logic [KEY_W-1:0]    key = '0;
  logic [HANDLE_W-1:0] new_handle = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [HANDLE_W-1:0] handle;
  logic                hit;
  logic                evict_valid;
  logic [HANDLE_W-1:0] evicted_handle;
  int                  mismatches;
  int                  pending;

  bit                  no_gaps = 1'b0;
  bit                  hold_results = 1'b0;
  logic [KEY_W-1:0]    key_pool [24];

  always #2 clk = ~clk;

  font_handle_mru_cache #(.BASIC_BITS(BASIC_BITS), .LIST_DEPTH(LIST_DEPTH)) uut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .op_i(op), .key_i(key), .new_handle_i(new_handle),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .handle_o(handle), .hit_o(hit),
    .evict_valid_o(evict_valid), .evicted_handle_o(evicted_handle)
  );

  handle_cache_checker #(.BASIC_BITS(BASIC_BITS), .LIST_DEPTH(LIST_DEPTH)) u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .op_i(op), .key_i(key), .new_handle_i(new_handle),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .handle_i(handle), .hit_i(hit),
    .evict_valid_i(evict_valid), .evicted_handle_i(evicted_handle),
    .mismatches_o(mismatches), .pending_o(pending)
  );

  task automatic offer_item(logic o, logic [KEY_W-1:0] k, logic [HANDLE_W-1:0] h);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    op         <= o;
    key        <= k;
    new_handle <= h;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // drain results, then let any table sweep run out
  task automatic settle();
    int unsigned n;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    n = 0;
    while (in_stall && n < (1 << BASIC_BITS) + 16) begin
      @(posedge clk);
      n++;
    end
  endtask

  task automatic write_strip_mask(logic [MASK_W-1:0] m);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35) return $urandom_range(0, (1 << BASIC_BITS) - 1);
    if (r < 80) return key_pool[$urandom_range(0, 23)];
    return $urandom;
  endfunction

  function automatic logic [HANDLE_W-1:0] pick_handle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 15) return '1;
    return $urandom;
  endfunction

  // result side: random stalls, one long hold-off on request
  initial begin
    int unsigned n;
    @(posedge clk);
    forever begin
      if (hold_results) begin
        out_stall <= 1'b1;
        repeat (60) @(posedge clk);
        hold_results = 1'b0;
      end
      n = no_gaps ? 0 : $urandom_range(0, 5);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!(out_valid && !out_stall)) @(posedge clk);
    end
  end

  initial begin
    logic [MASK_W-1:0] masks [6];
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    write_strip_mask('0);
    offer_item(OP_LOOKUP, 32'h0, 32'h0);
    offer_item(OP_LOOKUP, 32'h0, 32'h5);
    offer_item(OP_LOOKUP, 32'h0, 32'h9);
    offer_item(OP_LOOKUP, 32'hFF, 32'hFFFF_FFFF);
    offer_item(OP_LOOKUP, 32'hFF, 32'h1);
    offer_item(OP_LOOKUP, 32'h100, 32'h0);
    offer_item(OP_LOOKUP, 32'h100, 32'h7);
    offer_item(OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    offer_item(OP_LOOKUP, 32'hFFFF_FFFF, 32'h3);
    // fill the list so the zero-handle entry and then a live one fall off
    for (int i = 0; i < 16; i++)
      offer_item(OP_LOOKUP, 32'h1000 + i * 32'h100, 32'hA000 + i);
    offer_item(OP_FLUSH, $urandom, $urandom);
    offer_item(OP_LOOKUP, 32'h0, 32'hA);

    masks[0] = 32'h0;
    masks[1] = 32'hFFFF_FFFF;
    masks[2] = 32'hFFFF_FF00;
    masks[3] = $urandom;
    masks[4] = $urandom & $urandom;
    masks[5] = 32'h0000_FFFF;
    for (int p = 0; p < 6; p++) begin
      write_strip_mask(masks[p]);
      foreach (key_pool[i])
        key_pool[i] = $urandom | (32'h1 << $urandom_range(BASIC_BITS, KEY_W - 1));
      no_gaps = (p == 2);
      if (p == 3) hold_results = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 4 && i == PHASE_ITEMS / 2) settle();
        if ($urandom_range(0, 49) == 0) offer_item(OP_FLUSH, $urandom, $urandom);
        else offer_item(OP_LOOKUP, pick_key(), pick_handle());
      end
    end
    no_gaps = 1'b0;

    settle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
